// File: hw/rtl/utt_pkg.sv
package utt_pkg;

	localparam int BYTE_W      = 8;
	localparam int UNIT_W      = 16;
	localparam int CP_W        = 21;
	localparam int SUM_W       = 22;
	localparam int LEAD_W      = 11;
	localparam int LEN_W       = 2;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [SUM_W-1:0]  PLANE1_BASE = 22'h01_0000;
	localparam logic [SUM_W-1:0]  CP_LIMIT    = 22'h11_0000;
	localparam logic [UNIT_W-1:0] ONE_BYTE_LIM = 16'h0080;
	localparam logic [UNIT_W-1:0] TWO_BYTE_LIM = 16'h0800;

	// where the next input byte falls within a unit or a pair
	typedef enum logic [3:0] {
		PH_UNIT_HI  = 4'b0001,
		PH_UNIT_LO  = 4'b0010,
		PH_TRAIL_HI = 4'b0100,
		PH_TRAIL_LO = 4'b1000
	} phase_t;

	// encoded length minus one
	typedef enum logic [LEN_W-1:0] {
		LEN_ONE   = 2'd0,
		LEN_TWO   = 2'd1,
		LEN_THREE = 2'd2,
		LEN_FOUR  = 2'd3
	} len_t;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		len_t            len;
	} cp_entry_t;

	// utf-8 byte number idx of a code point whose encoding has len+1 bytes
	function automatic logic [BYTE_W-1:0] enc_byte(
		input logic [CP_W-1:0]  cp,
		input len_t             len,
		input logic [LEN_W-1:0] idx
	);
		logic [BYTE_W-1:0] b;
		b = {2'b10, cp[5:0]};
		case (len)
			LEN_ONE: b = {1'b0, cp[6:0]};
			LEN_TWO: begin
				case (idx)
					2'd0:    b = {3'b110, cp[10:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			LEN_THREE: begin
				case (idx)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			LEN_FOUR: begin
				case (idx)
					2'd0:    b = {5'b11110, cp[20:18]};
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: b = {2'b10, cp[5:0]};
		endcase
		return b;
	endfunction

endpackage

// File: hw/rtl/utt_if.sv
interface utt_byte_if;
	import utt_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface utt_utf8_if;
	import utt_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: hw/rtl/utt_front.sv
module utt_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [utt_pkg::BYTE_W-1:0] in_byte,
	output logic                     in_ready,
	input  logic                     q_full,
	output logic                     push,
	output utt_pkg::cp_entry_t       push_entry
);
	import utt_pkg::*;

	phase_t              phase_q;
	logic [BYTE_W-1:0]   held_q;
	logic [LEAD_W-1:0]   lead_q;
	logic [UNIT_W-1:0]   unit;
	logic                is_sur;
	logic [SUM_W-1:0]    pair_sum;
	logic                accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign unit     = {held_q, in_byte};
	assign is_sur   = (unit[15:11] == 5'b11011);
	// lead minus 0xd800 is just its low 11 bits
	assign pair_sum = SUM_W'({lead_q, unit[9:0]}) + PLANE1_BASE;

	always_comb begin
		push           = 1'b0;
		push_entry.cp  = {5'd0, unit};
		push_entry.len = LEN_THREE;
		case (phase_q)
			PH_UNIT_LO: begin
				push = accept && !is_sur;
				if (unit < ONE_BYTE_LIM) begin
					push_entry.len = LEN_ONE;
				end else if (unit < TWO_BYTE_LIM) begin
					push_entry.len = LEN_TWO;
				end
			end
			PH_TRAIL_LO: begin
				// lone trail taken as lead lands past the last plane
				push           = accept && (pair_sum < CP_LIMIT);
				push_entry.cp  = pair_sum[CP_W-1:0];
				push_entry.len = LEN_FOUR;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_UNIT_HI;
		end else if (accept) begin
			case (phase_q)
				PH_UNIT_HI:  phase_q <= PH_UNIT_LO;
				PH_UNIT_LO:  phase_q <= is_sur ? PH_TRAIL_HI : PH_UNIT_HI;
				PH_TRAIL_HI: phase_q <= PH_TRAIL_LO;
				default:     phase_q <= PH_UNIT_HI;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (phase_q == PH_UNIT_HI || phase_q == PH_TRAIL_HI)) begin
			held_q <= in_byte;
		end
		if (accept && phase_q == PH_UNIT_LO) begin
			lead_q <= unit[LEAD_W-1:0];
		end
	end

endmodule

// File: hw/rtl/utt_queue.sv
module utt_queue #(
	parameter int Depth = utt_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  utt_pkg::cp_entry_t push_entry,
	output logic               full,
	input  logic               pop,
	output logic               q_valid,
	output utt_pkg::cp_entry_t q_entry
);
	import utt_pkg::*;

	localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CNT_W = $clog2(Depth + 1);

	cp_entry_t        mem_q [Depth];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(Depth));
	assign q_valid = (count_q != '0);
	assign q_entry = mem_q[rd_ptr_q];
	assign do_pop  = pop && q_valid;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// File: hw/rtl/utt_back.sv
module utt_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  utt_pkg::cp_entry_t         q_entry,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [utt_pkg::BYTE_W-1:0] out_byte,
	output logic                       last_of_run
);
	import utt_pkg::*;

	logic              busy_q;
	logic [CP_W-1:0]   cp_q;
	len_t              len_q;
	logic [LEN_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              load;
	logic              emit;
	logic              is_last;
	logic              done;

	assign load    = !out_valid_q || out_ready;
	assign emit    = load && busy_q;
	assign is_last = (idx_q == LEN_W'(len_q));
	assign done    = emit && is_last;
	// next code point is picked up in the cycle its predecessor's last byte leaves
	assign pop     = q_valid && (!busy_q || done);

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cp_q  <= q_entry.cp;
			len_q <= q_entry.len;
		end
		if (emit) begin
			out_byte_q <= enc_byte(cp_q, len_q, idx_q);
			out_last_q <= is_last;
		end
	end

endmodule

// File: hw/rtl/utf16be_to_utf8_transcoder.sv
// channel   dir  payload                      transfer
// utf16     in   in_byte[7:0]                 valid && ready
// utf8      out  out_byte[7:0], last_of_run   valid && ready
//
// one input byte is taken per cycle while the code point queue has room
// one utf-8 byte leaves per cycle from the output register while utf8.ready
// is high, so a code point of n bytes holds the encoder until all n are out
// the first output byte of a unit passes through the queue, the encoder's code
// point register and the output register after the low byte of the unit
// arst_n clears the byte phase, the queue and the output valid
// a stalled output backs up into the queue, and utf16.ready drops when it is full
module utf16be_to_utf8_transcoder #(
	parameter int QueueDepth = utt_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	utt_byte_if.sink   utf16,
	utt_utf8_if.source utf8
);
	import utt_pkg::*;

	logic      q_full;
	logic      push;
	cp_entry_t push_entry;
	logic      pop;
	logic      q_valid;
	cp_entry_t q_entry;

	utt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (utf16.valid),
		.in_byte    (utf16.in_byte),
		.in_ready   (utf16.ready),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	utt_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.q_valid    (q_valid),
		.q_entry    (q_entry)
	);

	utt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.pop         (pop),
		.out_valid   (utf8.valid),
		.out_ready   (utf8.ready),
		.out_byte    (utf8.out_byte),
		.last_of_run (utf8.last_of_run)
	);

endmodule

// File: hw/rtl/utt_checker.sv
module utt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last_of_run
);

	logic out_xfer;
	logic at_start_q;

	assign out_xfer = out_valid && out_ready;

	// next transfer opens a new code point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
		end else if (out_xfer) begin
			at_start_q <= last_of_run;
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("utf8 valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(last_of_run))
		else $error("utf8 payload changed while stalled");

	a_lead_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && at_start_q |-> out_byte[7:6] != 2'b10)
		else $error("code point opens with a continuation byte");

	a_cont_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !at_start_q |-> out_byte[7:6] == 2'b10)
		else $error("lead byte inside a code point");

	a_ascii_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && at_start_q && !out_byte[7] |-> last_of_run)
		else $error("ascii byte not marked last");

endmodule

bind utf16be_to_utf8_transcoder utt_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (utf8.valid),
	.out_ready   (utf8.ready),
	.out_byte    (utf8.out_byte),
	.last_of_run (utf8.last_of_run)
);

// File: tb/sv/utf16be_to_utf8_transcoder_tb.sv
`timescale 1ns / 100ps

module utf16be_to_utf8_transcoder_tb;
	import utt_pkg::*;

	localparam logic [15:0] SURR_FIRST  = 16'hD800;
	localparam logic [15:0] SURR_LAST   = 16'hDFFF;
	localparam logic [15:0] TRAIL_FIRST = 16'hDC00;
	localparam logic [21:0] SUPP_BASE   = 22'h01_0000;
	localparam logic [21:0] CP_END      = 22'h11_0000;
	localparam int RANDOM_PER_PHASE     = 83;
	localparam int DIRECTED_ROWS        = 28;

	typedef struct packed {
		logic [7:0] ob;
		logic       last;
	} utf8_byte_t;

	// typed rows carry their utf-8 bytes left aligned, first byte in [31:24]
	typedef struct packed {
		logic [7:0]  in_b;
		logic        typed;
		logic [2:0]  n_out;
		logic [31:0] utf8;
	} stim_row_t;

	logic clk;
	logic arst_n;

	utt_byte_if utf16_bus ();
	utt_utf8_if utf8_bus ();

	utf16be_to_utf8_transcoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.utf16  (utf16_bus),
		.utf8   (utf8_bus)
	);

	// transcoder state as predicted
	phase_t      unit_phase;
	logic [7:0]  held_hi;
	logic [15:0] lead_held;

	utf8_byte_t point_bytes[$];
	utf8_byte_t utf8_expect[$];
	stim_row_t  row_plan[$];
	stim_row_t  directed_rows [0:DIRECTED_ROWS-1];

	int errors = 0;
	int src_idle;
	int sink_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic encode_point(input logic [21:0] cp);
		if (cp < 22'h80) begin
			point_bytes.push_back({cp[7:0], 1'b1});
		end else if (cp < 22'h800) begin
			point_bytes.push_back({3'b110, cp[10:6], 1'b0});
			point_bytes.push_back({2'b10, cp[5:0], 1'b1});
		end else if (cp < SUPP_BASE) begin
			point_bytes.push_back({4'b1110, cp[15:12], 1'b0});
			point_bytes.push_back({2'b10, cp[11:6], 1'b0});
			point_bytes.push_back({2'b10, cp[5:0], 1'b1});
		end else if (cp < CP_END) begin
			point_bytes.push_back({5'b11110, cp[20:18], 1'b0});
			point_bytes.push_back({2'b10, cp[17:12], 1'b0});
			point_bytes.push_back({2'b10, cp[11:6], 1'b0});
			point_bytes.push_back({2'b10, cp[5:0], 1'b1});
		end
		// pairs led by a lone trail land above the code space and emit nothing
	endtask

	task automatic transcode_byte(input logic [7:0] b);
		logic [15:0] unit;
		logic [15:0] lead_off;
		logic [21:0] cp;
		point_bytes.delete();
		unit = {held_hi, b};
		case (unit_phase)
			PH_UNIT_HI: begin
				held_hi = b;
				unit_phase = PH_UNIT_LO;
			end
			PH_UNIT_LO: begin
				if (unit >= SURR_FIRST && unit <= SURR_LAST) begin
					lead_held = unit;
					unit_phase = PH_TRAIL_HI;
				end else begin
					unit_phase = PH_UNIT_HI;
					encode_point({6'd0, unit});
				end
			end
			PH_TRAIL_HI: begin
				held_hi = b;
				unit_phase = PH_TRAIL_LO;
			end
			default: begin
				// trail is not checked, only its low ten bits count
				unit_phase = PH_UNIT_HI;
				lead_off = lead_held - SURR_FIRST;
				cp = {1'b0, lead_off[10:0], unit[9:0]} + SUPP_BASE;
				encode_point(cp);
			end
		endcase
	endtask

	task automatic take_utf16_byte(input logic [7:0] b);
		stim_row_t row;
		transcode_byte(b);
		row = row_plan.pop_front();
		if (row.typed) begin
			for (int k = 0; k < row.n_out; k++)
				utf8_expect.push_back({row.utf8[31-8*k -: 8], k == row.n_out - 1});
		end else begin
			foreach (point_bytes[k])
				utf8_expect.push_back(point_bytes[k]);
		end
	endtask

	task automatic check_utf8_byte(input logic [7:0] ob, input logic last);
		utf8_byte_t want;
		if (utf8_expect.size() == 0) begin
			report_mismatch($sformatf("unexpected utf-8 byte %02h last %0b", ob, last));
			return;
		end
		want = utf8_expect.pop_front();
		if (ob !== want.ob)
			report_mismatch($sformatf("out_byte %02h, want %02h", ob, want.ob));
		if (last !== want.last)
			report_mismatch($sformatf("last_of_run %0b, want %0b on byte %02h",
				last, want.last, want.ob));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (utf16_bus.valid && utf16_bus.ready)
				take_utf16_byte(utf16_bus.in_byte);
			if (utf8_bus.valid && utf8_bus.ready)
				check_utf8_byte(utf8_bus.out_byte, utf8_bus.last_of_run);
		end
	end

	always @(negedge clk)
		utf8_bus.ready = ($urandom_range(99) >= sink_idle);

	task automatic send_item(input stim_row_t row);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			utf16_bus.valid = 1'b0;
			@(negedge clk);
		end
		row_plan.push_back(row);
		utf16_bus.in_byte = row.in_b;
		utf16_bus.valid = 1'b1;
		@(posedge clk);
		while (!utf16_bus.ready)
			@(posedge clk);
	endtask

	task automatic send_unit(input logic [15:0] u);
		send_item({u[15:8], 1'b0, 3'd0, 32'd0});
		send_item({u[7:0], 1'b0, 3'd0, 32'd0});
	endtask

	task automatic send_random_group(output int n_bytes);
		int pick;
		logic [15:0] u;
		pick = $urandom_range(99);
		n_bytes = 4;
		if (pick < 15) begin
			send_unit(16'($urandom_range(16'h007F)));
			n_bytes = 2;
		end else if (pick < 30) begin
			send_unit(16'($urandom_range(16'h0080, 16'h07FF)));
			n_bytes = 2;
		end else if (pick < 50) begin
			// three-byte range with the surrogate block stepped over
			u = 16'($urandom_range(16'h0800, 16'hF7FF));
			if (u >= SURR_FIRST)
				u += 16'h0800;
			send_unit(u);
			n_bytes = 2;
		end else if (pick < 75) begin
			send_unit(16'($urandom_range(SURR_FIRST, TRAIL_FIRST - 16'd1)));
			send_unit(16'($urandom_range(TRAIL_FIRST, SURR_LAST)));
		end else if (pick < 83) begin
			send_unit(16'($urandom_range(TRAIL_FIRST, SURR_LAST)));
			send_unit(16'($urandom_range(16'hFFFF)));
		end else if (pick < 90) begin
			send_unit(16'($urandom_range(SURR_FIRST, TRAIL_FIRST - 16'd1)));
			send_unit(16'($urandom_range(16'hFFFF)));
		end else begin
			send_unit(16'($urandom_range(16'hFFFF)));
			n_bytes = 2;
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		utf16_bus.valid = 1'b0;
		while (utf8_expect.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int sent;
		int n;
		bit paused;
		utf16_bus.valid = 1'b0;
		utf16_bus.in_byte = 8'h00;
		utf8_bus.ready = 1'b0;
		arst_n = 1'b0;
		src_idle = 38;
		sink_idle = 88;
		paused = 1'b0;
		unit_phase = PH_UNIT_HI;
		held_hi = 8'h00;
		lead_held = 16'h0000;

		directed_rows = '{
			// bmp extremes and length boundaries
			'{8'h00, 1'b1, 3'd0, 32'h0}, '{8'h00, 1'b1, 3'd1, 32'h0000_0000},
			'{8'h00, 1'b1, 3'd0, 32'h0}, '{8'h7F, 1'b1, 3'd1, 32'h7F00_0000},
			'{8'h00, 1'b1, 3'd0, 32'h0}, '{8'h80, 1'b1, 3'd2, 32'hC280_0000},
			'{8'h07, 1'b1, 3'd0, 32'h0}, '{8'hFF, 1'b1, 3'd2, 32'hDFBF_0000},
			'{8'h08, 1'b1, 3'd0, 32'h0}, '{8'h00, 1'b1, 3'd3, 32'hE0A0_8000},
			'{8'hFF, 1'b1, 3'd0, 32'h0}, '{8'hFF, 1'b1, 3'd3, 32'hEFBF_BF00},
			// lowest and highest surrogate pairs
			'{8'hD8, 1'b1, 3'd0, 32'h0}, '{8'h00, 1'b1, 3'd0, 32'h0},
			'{8'hDC, 1'b1, 3'd0, 32'h0}, '{8'h00, 1'b1, 3'd4, 32'hF090_8080},
			'{8'hDB, 1'b1, 3'd0, 32'h0}, '{8'hFF, 1'b1, 3'd0, 32'h0},
			'{8'hDF, 1'b1, 3'd0, 32'h0}, '{8'hFF, 1'b1, 3'd4, 32'hF48F_BFBF},
			// lone trail taken as lead gives nothing
			'{8'hDF, 1'b1, 3'd0, 32'h0}, '{8'hFF, 1'b1, 3'd0, 32'h0},
			'{8'h00, 1'b1, 3'd0, 32'h0}, '{8'h41, 1'b1, 3'd0, 32'h0},
			// lead followed by a unit that is no trail
			'{8'hD8, 1'b1, 3'd0, 32'h0}, '{8'h00, 1'b1, 3'd0, 32'h0},
			'{8'h00, 1'b1, 3'd0, 32'h0}, '{8'h41, 1'b0, 3'd0, 32'h0}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i]);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle = 38;
					sink_idle = 88;
				end
				1: begin
					src_idle = 88;
					sink_idle = 38;
				end
				default: begin
					src_idle = 0;
					sink_idle = 0;
				end
			endcase
			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				send_random_group(n);
				sent += n;
				if (!paused && sent >= 40) begin
					// hold the sender until the output side has caught up
					wait_drained();
					paused = 1'b1;
				end
			end
			wait_drained();
		end

		// an odd byte at the end of the stream stays held
		send_item({8'hA5, 1'b0, 3'd0, 32'd0});
		wait_drained();
		repeat (40) @(negedge clk);

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
